### hw/rtl/pdks_pkg.sv
// Package with the shared sizes, codes, beat types and helper functions of the key search block.
`default_nettype none
package pdks_pkg;

    // Sizes of the key set and of the prefix directory.
    localparam int PREFIX_BITS = 12;
    localparam int CAPACITY    = 4096;
    localparam int KEY_W       = 64;
    localparam int POS_W       = 12;
    localparam int DIR_LAST    = 1 << PREFIX_BITS;
    localparam int DIR_DEPTH   = DIR_LAST + 1;
    localparam int DIR_AW      = $clog2(DIR_DEPTH);
    localparam int NUP_W       = $clog2(DIR_DEPTH + 1);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int KEY_AW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // Operation codes of an input beat.
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_SEAL   = 2'd2,
        OP_LOOKUP = 2'd3
    } t_op;

    // Status codes of a result beat.
    typedef enum logic [2:0] {
        ST_ACCEPTED  = 3'd0,
        ST_FOUND     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_ORDER     = 3'd4,
        ST_PHASE     = 3'd5
    } t_status;

    typedef struct packed {
        t_op                      operation;
        logic signed [KEY_W-1:0]  key;
    } t_in;

    typedef struct packed {
        t_status                  status;
        logic [POS_W-1:0]         position;
    } t_out;

    // Directory index of a key: its top bits after the sign bit is flipped.
    function automatic logic [PREFIX_BITS-1:0] prefix_of(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] f;
        f = {~k[KEY_W-1], k[KEY_W-2:0]};
        return f[KEY_W-1 -: PREFIX_BITS];
    endfunction

    // Reports a key index on the fixed-width position field.
    function automatic logic [POS_W-1:0] to_pos(input logic [CNT_W-1:0] v);
        logic [CNT_W+POS_W-1:0] t;
        t = {{POS_W{1'b0}}, v};
        return t[POS_W-1:0];
    endfunction

endpackage
`default_nettype wire

### hw/rtl/prefix_directory_key_search.sv
// Top level of the prefix directory key search block: control sequencer and the two memories.
//
// Usage: an input beat (operation and key on i_item) is taken at a rising edge where
// start is high and busy is low. Every beat produces exactly one result beat on
// o_result, shown for one cycle with o_strobe high; the receiver cannot stall it.
// Keys are appended in nondecreasing signed order, then the directory is sealed,
// then lookups may run. A clear returns the set to the empty, unsealed phase.
//
// Steps of each operation, from the accepting edge to the result:
//   clear, any rejected beat, append that fills no directory entry: result registered at once.
//   append that fills entries: one directory write a cycle for each entry filled.
//   seal: one directory write a cycle for each remaining directory entry.
//   lookup: the two directory words come through the single read port one after
//   another, then the bucket keys are scanned, one key store read a cycle.
// busy is low again in the cycle the result is shown, so the next beat may be
// accepted at the edge that takes the result.
// Reset clears the key count, the fill pointer and the seal flag; the memories are
// not cleared, since no entry is read before it has been written since a clear.
`default_nettype none
module prefix_directory_key_search (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire pdks_pkg::t_in  i_item,
    output logic              o_strobe,
    output pdks_pkg::t_out    o_result
);
    import pdks_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_LK_LO,
        S_LK_HI,
        S_SCAN
    } t_state;

    t_state                  r_state, n_state;
    logic                    r_strobe, n_strobe;
    t_out                    r_result, n_result;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [NUP_W-1:0]        r_nup, n_nup;
    logic signed [KEY_W-1:0] r_prev, n_prev;
    logic                    r_sealed, n_sealed;
    logic [NUP_W-1:0]        r_fill_last, n_fill_last;
    logic [CNT_W-1:0]        r_fill_val, n_fill_val;
    logic [DIR_AW-1:0]       r_h, n_h;
    logic [CNT_W-1:0]        r_lo, n_lo;
    logic [CNT_W-1:0]        r_hi, n_hi;
    logic [CNT_W-1:0]        r_idx, n_idx;
    logic signed [KEY_W-1:0] r_key, n_key;

    logic                    dir_we;
    logic [DIR_AW-1:0]       dir_waddr;
    logic [DIR_AW-1:0]       dir_raddr;
    logic [CNT_W-1:0]        dir_rdata;
    logic                    key_we;
    logic [KEY_AW-1:0]       key_waddr;
    logic [KEY_AW-1:0]       key_raddr;
    logic [KEY_W-1:0]        key_rdata;

    logic                    accept;
    logic [PREFIX_BITS-1:0]  in_pfx;
    logic [CNT_W-1:0]        hi_clamped;
    logic [CNT_W-1:0]        idx_next;

    assign accept     = start && !busy;
    assign in_pfx     = prefix_of(i_item.key);
    assign hi_clamped = (dir_rdata > r_count) ? r_count : dir_rdata;
    assign idx_next   = r_idx + CNT_W'(1);

    // Directory of bucket start positions.
    pdks_ram #(.DEPTH(DIR_DEPTH), .WIDTH(CNT_W)) u_dir (
        .i_clk   (i_clk),
        .i_we    (dir_we),
        .i_waddr (dir_waddr),
        .i_wdata (r_fill_val),
        .i_raddr (dir_raddr),
        .o_rdata (dir_rdata)
    );

    // Store of appended keys.
    pdks_ram #(.DEPTH(CAPACITY), .WIDTH(KEY_W)) u_keys (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (i_item.key),
        .i_raddr (key_raddr),
        .o_rdata (key_rdata)
    );

    // Sequencer: decides each operation, steps the directory fill and the bucket scan.
    always_comb begin
        n_state     = r_state;
        n_strobe    = 1'b0;
        n_result    = r_result;
        n_count     = r_count;
        n_nup       = r_nup;
        n_prev      = r_prev;
        n_sealed    = r_sealed;
        n_fill_last = r_fill_last;
        n_fill_val  = r_fill_val;
        n_h         = r_h;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_idx       = r_idx;
        n_key       = r_key;
        dir_we      = 1'b0;
        dir_waddr   = r_nup[DIR_AW-1:0];
        dir_raddr   = DIR_AW'(in_pfx);
        key_we      = 1'b0;
        key_waddr   = r_count[KEY_AW-1:0];
        key_raddr   = r_lo[KEY_AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_result.position = '0;
                    n_result.status   = ST_ACCEPTED;
                    unique case (i_item.operation)
                        OP_CLEAR: begin
                            n_count  = '0;
                            n_nup    = '0;
                            n_sealed = 1'b0;
                            n_strobe = 1'b1;
                        end
                        OP_APPEND: begin
                            priority if (r_sealed) begin
                                n_result.status = ST_PHASE;
                                n_strobe        = 1'b1;
                            end else if (r_count >= CNT_W'(CAPACITY)) begin
                                n_result.status = ST_FULL;
                                n_strobe        = 1'b1;
                            end else if (r_count != '0 && i_item.key < r_prev) begin
                                n_result.status = ST_ORDER;
                                n_strobe        = 1'b1;
                            end else begin
                                key_we      = 1'b1;
                                n_count     = r_count + CNT_W'(1);
                                n_prev      = i_item.key;
                                n_fill_val  = r_count;
                                n_fill_last = NUP_W'(in_pfx);
                                if (r_nup <= NUP_W'(in_pfx)) begin
                                    n_state = S_FILL;
                                end else begin
                                    n_strobe = 1'b1;
                                end
                            end
                        end
                        OP_SEAL: begin
                            if (r_sealed) begin
                                n_result.status = ST_PHASE;
                                n_strobe        = 1'b1;
                            end else begin
                                n_sealed    = 1'b1;
                                n_fill_val  = r_count;
                                n_fill_last = NUP_W'(DIR_LAST);
                                if (r_nup <= NUP_W'(DIR_LAST)) begin
                                    n_state = S_FILL;
                                end else begin
                                    n_strobe = 1'b1;
                                end
                            end
                        end
                        OP_LOOKUP: begin
                            if (!r_sealed) begin
                                n_result.status = ST_PHASE;
                                n_strobe        = 1'b1;
                            end else begin
                                n_h     = DIR_AW'(in_pfx);
                                n_key   = i_item.key;
                                n_state = S_LK_LO;
                            end
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
            S_FILL: begin
                // One directory entry a cycle up to and including the fill's last entry.
                dir_we = 1'b1;
                n_nup  = r_nup + NUP_W'(1);
                if (r_nup == r_fill_last) begin
                    n_state  = S_IDLE;
                    n_strobe = 1'b1;
                end
            end
            S_LK_LO: begin
                // Bucket start has arrived; fetch the next bucket's start as the end.
                n_lo      = dir_rdata;
                dir_raddr = r_h + DIR_AW'(1);
                n_state   = S_LK_HI;
            end
            S_LK_HI: begin
                if (r_lo < hi_clamped) begin
                    n_hi    = hi_clamped;
                    n_idx   = r_lo;
                    n_state = S_SCAN;
                end else begin
                    n_result.status = ST_NOT_FOUND;
                    n_state         = S_IDLE;
                    n_strobe        = 1'b1;
                end
            end
            S_SCAN: begin
                // Compare one stored key a cycle, reading the next one ahead.
                key_raddr = idx_next[KEY_AW-1:0];
                if (key_rdata == r_key) begin
                    n_result.status   = ST_FOUND;
                    n_result.position = to_pos(r_idx);
                    n_state           = S_IDLE;
                    n_strobe          = 1'b1;
                end else if (idx_next < r_hi) begin
                    n_idx = idx_next;
                end else begin
                    n_result.status = ST_NOT_FOUND;
                    n_state         = S_IDLE;
                    n_strobe        = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, control registers and the registered result beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_count  <= '0;
            r_nup    <= '0;
            r_prev   <= '0;
            r_sealed <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_count  <= n_count;
            r_nup    <= n_nup;
            r_prev   <= n_prev;
            r_sealed <= n_sealed;
        end
        r_result    <= n_result;
        r_fill_last <= n_fill_last;
        r_fill_val  <= n_fill_val;
        r_h         <= n_h;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_idx       <= n_idx;
        r_key       <= n_key;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // A result beat leaves the block free for the next input beat.
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result shown while busy");

    // Every accepted beat either answers at once or keeps the block busy.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (busy || o_strobe))
        else $error("accepted beat produced no result and no work");

    // The key count never passes the capacity.
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("key count beyond capacity");

    // Once a seal has finished, the whole directory has been filled.
    a_sealed_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sealed && r_state == S_IDLE) |-> (r_nup == NUP_W'(DIR_DEPTH)))
        else $error("sealed with unfilled directory entries");

    // The fill pointer stays within one past the closing entry.
    a_nup_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nup <= NUP_W'(DIR_DEPTH))
        else $error("fill pointer out of range");

endmodule
`default_nettype wire

### hw/rtl/pdks_ram.sv
// Simple dual-port synchronous RAM with one write port and one registered read port.
`default_nettype none
module pdks_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 64
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                             i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire
